### design/mwd_pkg.sv
// ----------------------------------------------------------------------------
// mwd_pkg: shared definitions for the multimode waveshaper distortion core
// Default sizes, shaping mode codes and configuration register indexes.
// ----------------------------------------------------------------------------
package mwd_pkg;

	// Default sizes for the core parameters.
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int CURVE_DEPTH_DEF = 1024;

	// Configuration port widths.
	localparam int CFG_INDEX_W = 8;
	localparam int CFG_DATA_W  = 17;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_DRIVE_GAIN = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_WET_MIX    = 8'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_SHAPE_MODE = 8'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_CLIP_LEVEL = 8'd3;

	// Shaping mode codes; the unused codes behave as bypass.
	localparam logic [2:0] MODE_SOFT   = 3'd0;
	localparam logic [2:0] MODE_HARD   = 3'd1;
	localparam logic [2:0] MODE_EXP    = 3'd2;
	localparam logic [2:0] MODE_FOLD   = 3'd3;
	localparam logic [2:0] MODE_BYPASS = 3'd4;

	// Reset values of the configuration registers.
	localparam logic [15:0] DRIVE_GAIN_RST = 16'd4096;
	localparam logic [16:0] WET_MIX_RST    = 17'd32768;
	localparam logic [2:0]  SHAPE_MODE_RST = MODE_SOFT;
	localparam logic [16:0] CLIP_LEVEL_RST = 17'd32768;

	// Unity in the internal Q.16 format.
	localparam logic [16:0] ONE_Q16 = 17'd65536;

endpackage

### design/multimode_waveshaper_distortion_core.sv
// ----------------------------------------------------------------------------
// multimode_waveshaper_distortion_core: drive, waveshape and dry/wet mix
// Soft (tanh), hard clip, exponential and foldback shaping of audio samples, or bypass.
// ----------------------------------------------------------------------------
// Samples arrive on the s_ stream (s_tdata holds the sample, s_tuser the
// channel tag) and leave on the m_ stream in the same packing. Settings are
// written through the cfg_ channel (index 0 drive gain, 1 wet mix, 2 shape
// mode, 3 clip level); the user is to write them only while no sample is in
// flight, which the core does not enforce. Writes to other indexes are
// dropped. cfg_ready is always high.
// One sample is accepted per clock cycle while s_tready is high. A result
// passes the front stages, the curve lookup, two pipelined dividers (33
// stages for the curve and fold remainder, 32 stages for the division by the
// drive) and the mix stages. After reset the exp curve RAM is loaded from a
// constant table, one entry a cycle; s_tready stays low until the load is
// done. The registers return to their reset values.
// When the receiver holds m_tready low with a result waiting, the whole
// pipeline holds and s_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module multimode_waveshaper_distortion_core
	import mwd_pkg::*;
#(
	parameter int SAMPLE_BITS       = SAMPLE_BITS_DEF,
	parameter int CURVE_TABLE_DEPTH = CURVE_DEPTH_DEF,
	localparam int DATA_W           = ((SAMPLE_BITS + 7) / 8) * 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [DATA_W-1:0]      s_tdata,   // sample_in
	input  logic [2:0]             s_tuser,   // channel_tag
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [DATA_W-1:0]      m_tdata,   // sample_out
	output logic [2:0]             m_tuser,   // channel_out
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	// Derived sizes.
	localparam int TAB_N     = CURVE_TABLE_DEPTH + 1;
	localparam int TAW       = $clog2(TAB_N);
	localparam int PW        = SAMPLE_BITS + 17;
	localparam int IN_SHIFT  = SAMPLE_BITS - 5;
	localparam int OUT_SHIFT = 33 - SAMPLE_BITS;
	localparam int XW        = 22;
	localparam int ARGW      = 22;
	localparam int POSW      = ARGW + TAW + 1;
	localparam int IDXW      = POSW - 20;
	localparam int YW        = 24;
	localparam int ACCW      = 52;
	localparam int D1_NW     = 33;
	localparam int D1_DW     = 19;
	localparam int D1_SW     = XW + 3 + 17;
	localparam int D2_NW     = 32;
	localparam int D2_DW     = 16;
	localparam int D2_SW     = XW + 3 + 1;
	localparam longint unsigned EXP_M1_Q30 = 64'd395007542;

	localparam logic signed [PW-1:0]   IN_HALF  = PW'(1) << (IN_SHIFT - 1);
	localparam logic signed [ACCW-1:0] OUT_HALF = ACCW'(1) << (OUT_SHIFT - 1);
	localparam logic signed [ACCW-1:0] OUT_MAX  =
		(ACCW'(1) << (SAMPLE_BITS - 1)) - ACCW'(1);
	localparam logic signed [ACCW-1:0] OUT_MIN  = -(ACCW'(1) << (SAMPLE_BITS - 1));

	typedef logic [16:0] exp_rom_t [TAB_N];

	// exp(-16*i/DEPTH) in Q1.16 from a Taylor series in Q2.30.
	function automatic exp_rom_t build_exp_rom();
		exp_rom_t          rom;
		longint unsigned   num;
		longint unsigned   whole;
		longint unsigned   rmd;
		longint unsigned   f;
		longint unsigned   term;
		longint unsigned   v;
		longint            sum;
		for (int i = 0; i < TAB_N; i++) begin
			num   = 64'(i) * 64'd16;
			whole = num / CURVE_TABLE_DEPTH;
			rmd   = num % CURVE_TABLE_DEPTH;
			f     = (rmd << 30) / CURVE_TABLE_DEPTH;
			term  = 64'd1 << 30;
			sum   = 64'sd1 <<< 30;
			for (int n = 1; n <= 20; n++) begin
				term = (term * f) >> 30;
				case (n)
					2:  term = term / 2;
					3:  term = term / 3;
					4:  term = term / 4;
					5:  term = term / 5;
					6:  term = term / 6;
					7:  term = term / 7;
					8:  term = term / 8;
					9:  term = term / 9;
					10: term = term / 10;
					11: term = term / 11;
					12: term = term / 12;
					13: term = term / 13;
					14: term = term / 14;
					15: term = term / 15;
					16: term = term / 16;
					17: term = term / 17;
					18: term = term / 18;
					19: term = term / 19;
					20: term = term / 20;
					default: term = term;
				endcase
				if ((n % 2) == 1) begin
					sum = sum - longint'(term);
				end else begin
					sum = sum + longint'(term);
				end
			end
			v = (sum > 0) ? longint'(sum) : 64'd0;
			while (whole > 0) begin
				v     = (v * EXP_M1_Q30) >> 30;
				whole = whole - 64'd1;
			end
			rom[i] = 17'((v + 64'd8192) >> 14);
		end
		return rom;
	endfunction

	localparam exp_rom_t EXP_ROM = build_exp_rom();

	// Configuration registers.
	logic [15:0] drive_gain_q;
	logic [16:0] wet_mix_q;
	logic [2:0]  shape_mode_q;
	logic [16:0] clip_level_q;

	// Curve RAM loading.
	logic           fill_busy_q;
	logic [TAW-1:0] fill_q;

	// Pipeline control.
	logic en;
	logic accept;

	// Stage registers.
	logic                   v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic                   v_s9, v_s10;
	logic signed [PW-1:0]   prod_s1;
	logic [2:0]             tag_s1, tag_s2, tag_s3, tag_s4, tag_s5, tag_s6, tag_s7;
	logic [2:0]             tag_s8, tag_s9, tag_s10;
	logic signed [XW-1:0]   x_s2, x_s3, x_s4, x_s5, x_s6, x_s7, x_s8, x_s9, x_s10;
	logic [ARGW-1:0]        arg_s3;
	logic [20:0]            fdiff_s3, fdiff_s4, fdiff_s5, fdiff_s6, fdiff_s7;
	logic [POSW-1:0]        pos_s4;
	logic [19:0]            frac_s5;
	logic signed [38:0]     dprod_s6;
	logic [16:0]            e0_s6;
	logic [16:0]            e_s7;
	logic [19:0]            ymag_s8;
	logic                   yneg_s8;
	logic signed [32:0]     wet_s9;
	logic signed [39:0]     p1_s10;
	logic signed [50:0]     p2_s10;
	logic                   out_vld_q;
	logic [SAMPLE_BITS-1:0] sample_out_q;
	logic [2:0]             channel_out_q;

	// Combinational signals.
	logic signed [PW-1:0]   prod_c;
	logic signed [PW-1:0]   xr_c;
	logic [XW-1:0]          absx_c;
	logic signed [YW-1:0]   xt_c;
	logic [YW-1:0]          absxt_c;
	logic [IDXW-1:0]        idx_c;
	logic                   idx_sat_c;
	logic [TAW-1:0]         addr_a_c, addr_b_c;
	logic [16:0]            tab_a, tab_b;
	logic                   ram_we;
	logic signed [17:0]     d_c;
	logic signed [19:0]     e_c;
	logic [D1_NW-1:0]       d1_num;
	logic [D1_DW-1:0]       d1_den;
	logic                   d1_vld;
	logic [D1_NW-1:0]       d1_quo;
	logic [D1_DW-1:0]       d1_rem;
	logic [D1_SW-1:0]       d1_side;
	logic signed [XW-1:0]   d1_x;
	logic [2:0]             d1_tag;
	logic [16:0]            d1_e;
	logic signed [YW-1:0]   xs_c, ts_c, y_c, fold_c, rr_c;
	logic [YW-1:0]          ymag_c;
	logic                   d2_vld;
	logic [D2_NW-1:0]       d2_quo;
	logic [D2_DW-1:0]       d2_rem;
	logic [D2_SW-1:0]       d2_side;
	logic signed [XW-1:0]   d2_x;
	logic [2:0]             d2_tag;
	logic                   d2_yneg;
	logic [16:0]            mix_c;
	logic [16:0]            dry_c;
	logic signed [ACCW-1:0] acc_c;
	logic signed [ACCW-1:0] o_c;
	logic [SAMPLE_BITS-1:0] sat_c;

	// Handshakes: the pipeline advances unless a finished result is held.
	assign en        = !out_vld_q || m_tready;
	assign s_tready  = en && !fill_busy_q;
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_gain_q <= DRIVE_GAIN_RST;
			wet_mix_q    <= WET_MIX_RST;
			shape_mode_q <= SHAPE_MODE_RST;
			clip_level_q <= CLIP_LEVEL_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_DRIVE_GAIN: drive_gain_q <= cfg_data[15:0];
				REG_WET_MIX:    wet_mix_q    <= cfg_data[16:0];
				REG_SHAPE_MODE: shape_mode_q <= cfg_data[2:0];
				REG_CLIP_LEVEL: clip_level_q <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	// Curve RAM load sweep after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_busy_q <= 1'b1;
			fill_q      <= '0;
		end else if (fill_busy_q) begin
			if (fill_q == TAW'(CURVE_TABLE_DEPTH)) begin
				fill_busy_q <= 1'b0;
			end else begin
				fill_q <= fill_q + TAW'(1);
			end
		end
	end

	assign ram_we = fill_busy_q;

	// Valid bits of the front and back stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			v_s5      <= 1'b0;
			v_s6      <= 1'b0;
			v_s7      <= 1'b0;
			v_s8      <= 1'b0;
			v_s9      <= 1'b0;
			v_s10     <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			v_s1      <= accept;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			v_s5      <= v_s4;
			v_s6      <= v_s5;
			v_s7      <= v_s6;
			v_s8      <= d1_vld;
			v_s9      <= d2_vld;
			v_s10     <= v_s9;
			out_vld_q <= v_s10;
		end
	end

	// Stage 1: driven product.
	assign prod_c = $signed(s_tdata[SAMPLE_BITS-1:0]) * $signed({1'b0, drive_gain_q});

	// Stage 2: round the product into Q.16.
	assign xr_c = (prod_s1 + IN_HALF) >>> IN_SHIFT;

	// Stage 3: magnitude, curve argument and fold distance.
	assign absx_c  = x_s2[XW-1] ? XW'(-x_s2) : XW'(x_s2);
	assign xt_c    = YW'(x_s2) - $signed({7'b0, clip_level_q});
	assign absxt_c = xt_c[YW-1] ? YW'(-xt_c) : YW'(xt_c);

	// Stage 4 read: table index, clamped at the end of the curve.
	assign idx_c     = pos_s4[POSW-1:20];
	assign idx_sat_c = (idx_c >= IDXW'(CURVE_TABLE_DEPTH));
	assign addr_a_c  = idx_sat_c ? TAW'(CURVE_TABLE_DEPTH) : idx_c[TAW-1:0];
	assign addr_b_c  = idx_sat_c ? TAW'(CURVE_TABLE_DEPTH) : idx_c[TAW-1:0] + TAW'(1);

	mwd_ram #(
		.WIDTH (17),
		.DEPTH (TAB_N)
	) u_curve_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (fill_q),
		.wdata   (EXP_ROM[fill_q]),
		.re      (en),
		.raddr_a (addr_a_c),
		.raddr_b (addr_b_c),
		.rdata_a (tab_a),
		.rdata_b (tab_b)
	);

	// Stage 6: slope times fraction.
	assign d_c = $signed({1'b0, tab_b}) - $signed({1'b0, tab_a});

	// Stage 7: interpolated exp(-a).
	assign e_c = $signed({3'b0, e0_s6}) + 20'(dprod_s6 >>> 20);

	// Front stage payload.
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1  <= prod_c;
			tag_s1   <= s_tuser;
			x_s2     <= xr_c[XW-1:0];
			tag_s2   <= tag_s1;
			arg_s3   <= (shape_mode_q == MODE_SOFT) ? {absx_c[20:0], 1'b0}
				: {1'b0, absx_c[20:0]};
			fdiff_s3 <= absxt_c[20:0];
			x_s3     <= x_s2;
			tag_s3   <= tag_s2;
			pos_s4   <= POSW'(arg_s3) * POSW'(CURVE_TABLE_DEPTH);
			fdiff_s4 <= fdiff_s3;
			x_s4     <= x_s3;
			tag_s4   <= tag_s3;
			frac_s5  <= idx_sat_c ? 20'd0 : pos_s4[19:0];
			fdiff_s5 <= fdiff_s4;
			x_s5     <= x_s4;
			tag_s5   <= tag_s4;
			dprod_s6 <= d_c * $signed({1'b0, frac_s5});
			e0_s6    <= tab_a;
			fdiff_s6 <= fdiff_s5;
			x_s6     <= x_s5;
			tag_s6   <= tag_s5;
			e_s7     <= e_c[16:0];
			fdiff_s7 <= fdiff_s6;
			x_s7     <= x_s6;
			tag_s7   <= tag_s6;
		end
	end

	// Shared divider: tanh ratio, or the fold remainder by four thresholds.
	assign d1_num = (shape_mode_q == MODE_FOLD) ? D1_NW'(fdiff_s7)
		: {ONE_Q16 - e_s7, 16'b0};
	assign d1_den = (shape_mode_q == MODE_FOLD) ? {clip_level_q, 2'b0}
		: D1_DW'(e_s7) + D1_DW'(ONE_Q16);

	mwd_udiv #(
		.NUM_W  (D1_NW),
		.DEN_W  (D1_DW),
		.SIDE_W (D1_SW)
	) u_curve_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (v_s7),
		.num      (d1_num),
		.den      (d1_den),
		.side_in  ({x_s7, tag_s7, e_s7}),
		.out_vld  (d1_vld),
		.quo      (d1_quo),
		.rem      (d1_rem),
		.side_out (d1_side)
	);

	assign d1_x   = d1_side[D1_SW-1 -: XW];
	assign d1_tag = d1_side[19:17];
	assign d1_e   = d1_side[16:0];

	// Stage 8: select the shaped value for the current mode.
	assign xs_c   = YW'(d1_x);
	assign ts_c   = $signed({7'b0, clip_level_q});
	assign rr_c   = $signed({5'b0, d1_rem}) - $signed({6'b0, clip_level_q, 1'b0});
	assign fold_c = (rr_c[YW-1] ? -rr_c : rr_c) - ts_c;

	always_comb begin
		case (shape_mode_q)
			MODE_SOFT: begin
				y_c = d1_x[XW-1] ? -$signed({7'b0, d1_quo[16:0]})
					: $signed({7'b0, d1_quo[16:0]});
			end
			MODE_HARD: begin
				if (xs_c > ts_c) begin
					y_c = ts_c;
				end else if (xs_c < -ts_c) begin
					y_c = -ts_c;
				end else begin
					y_c = xs_c;
				end
			end
			MODE_EXP: begin
				if (xs_c == '0) begin
					y_c = '0;
				end else if (d1_x[XW-1]) begin
					y_c = $signed({7'b0, d1_e}) - $signed({7'b0, ONE_Q16});
				end else begin
					y_c = $signed({7'b0, ONE_Q16}) - $signed({7'b0, d1_e});
				end
			end
			MODE_FOLD: begin
				if (xs_c > ts_c || xs_c < -ts_c) begin
					y_c = (clip_level_q == '0) ? '0 : fold_c;
				end else begin
					y_c = xs_c;
				end
			end
			default: y_c = xs_c;
		endcase
	end

	assign ymag_c = y_c[YW-1] ? YW'(-y_c) : YW'(y_c);

	always_ff @(posedge clk) begin
		if (en) begin
			ymag_s8 <= ymag_c[19:0];
			yneg_s8 <= y_c[YW-1];
			x_s8    <= d1_x;
			tag_s8  <= d1_tag;
		end
	end

	// Undo the drive: magnitude times 4096 over the gain.
	mwd_udiv #(
		.NUM_W  (D2_NW),
		.DEN_W  (D2_DW),
		.SIDE_W (D2_SW)
	) u_gain_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (v_s8),
		.num      ({ymag_s8, 12'b0}),
		.den      (drive_gain_q),
		.side_in  ({x_s8, tag_s8, yneg_s8}),
		.out_vld  (d2_vld),
		.quo      (d2_quo),
		.rem      (d2_rem),
		.side_out (d2_side)
	);

	assign d2_x    = d2_side[D2_SW-1 -: XW];
	assign d2_tag  = d2_side[3:1];
	assign d2_yneg = d2_side[0] && (d2_rem == d2_rem);

	// Mix weights, wet fraction limited to unity.
	assign mix_c = (wet_mix_q > ONE_Q16) ? ONE_Q16 : wet_mix_q;
	assign dry_c = ONE_Q16 - mix_c;

	// Rounding and saturation of the mixed sum.
	assign acc_c = ACCW'(p1_s10) + ACCW'(p2_s10) + OUT_HALF;
	assign o_c   = acc_c >>> OUT_SHIFT;
	assign sat_c = (o_c > OUT_MAX) ? OUT_MAX[SAMPLE_BITS-1:0]
		: (o_c < OUT_MIN) ? OUT_MIN[SAMPLE_BITS-1:0] : o_c[SAMPLE_BITS-1:0];

	// Back stage payload.
	always_ff @(posedge clk) begin
		if (en) begin
			if (drive_gain_q == '0) begin
				wet_s9 <= '0;
			end else if (d2_yneg) begin
				wet_s9 <= -$signed({1'b0, d2_quo});
			end else begin
				wet_s9 <= $signed({1'b0, d2_quo});
			end
			x_s9          <= d2_x;
			tag_s9        <= d2_tag;
			p1_s10        <= x_s9 * $signed({1'b0, dry_c});
			p2_s10        <= wet_s9 * $signed({1'b0, mix_c});
			x_s10         <= x_s9;
			tag_s10       <= tag_s9;
			sample_out_q  <= sat_c;
			channel_out_q <= tag_s10;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = DATA_W'(sample_out_q) | DATA_W'(x_s10 & '0);
	assign m_tuser  = channel_out_q;

	// No request is taken while the curve RAM is being loaded.
	assert property (@(posedge clk) disable iff (!arst_n) fill_busy_q |-> !s_tready)
		else $error("request accepted during curve load");

	// A held result blocks new requests.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !m_tready) |-> !s_tready)
		else $error("request accepted while output stalled");

	// The load sweep runs once after reset.
	assert property (@(posedge clk) disable iff (!arst_n)
		!fill_busy_q |=> !fill_busy_q)
		else $error("curve load restarted");

	// An accepted request enters the first stage.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> v_s1)
		else $error("accepted request lost at stage one");

endmodule

### design/mwd_ram.sv
// ----------------------------------------------------------------------------
// mwd_ram: generic RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module mwd_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 1025
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read ports.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

### design/mwd_udiv.sv
// ----------------------------------------------------------------------------
// mwd_udiv: pipelined unsigned restoring divider
// One quotient bit per stage, NUM_W stages; a side vector travels alongside.
// ----------------------------------------------------------------------------
module mwd_udiv #(
	parameter int NUM_W  = 33,
	parameter int DEN_W  = 19,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_vld,
	output logic [NUM_W-1:0]  quo,
	output logic [DEN_W-1:0]  rem,
	output logic [SIDE_W-1:0] side_out
);

	// Stage registers, index k holds the state after stage k+1.
	logic              vld_s  [NUM_W];
	logic [NUM_W-1:0]  num_s  [NUM_W];
	logic [NUM_W-1:0]  quo_s  [NUM_W];
	logic [DEN_W-1:0]  rem_s  [NUM_W];
	logic [DEN_W-1:0]  den_s  [NUM_W];
	logic [SIDE_W-1:0] side_s [NUM_W];

	// Stage inputs and next values.
	logic [NUM_W-1:0]  src_num  [NUM_W];
	logic [NUM_W-1:0]  src_quo  [NUM_W];
	logic [DEN_W-1:0]  src_rem  [NUM_W];
	logic [DEN_W-1:0]  src_den  [NUM_W];
	logic [SIDE_W-1:0] src_side [NUM_W];
	logic [NUM_W-1:0]  nxt_num  [NUM_W];
	logic [NUM_W-1:0]  nxt_quo  [NUM_W];
	logic [DEN_W-1:0]  nxt_rem  [NUM_W];

	// Each stage brings down one dividend bit and subtracts where it can.
	always_comb begin
		logic [DEN_W:0] trial;
		logic [DEN_W:0] diff;
		logic           ge;
		for (int k = 0; k < NUM_W; k++) begin
			if (k == 0) begin
				src_num[k]  = num;
				src_quo[k]  = '0;
				src_rem[k]  = '0;
				src_den[k]  = den;
				src_side[k] = side_in;
			end else begin
				src_num[k]  = num_s[k-1];
				src_quo[k]  = quo_s[k-1];
				src_rem[k]  = rem_s[k-1];
				src_den[k]  = den_s[k-1];
				src_side[k] = side_s[k-1];
			end
			trial      = {src_rem[k], src_num[k][NUM_W-1]};
			diff       = trial - {1'b0, src_den[k]};
			ge         = (trial >= {1'b0, src_den[k]});
			nxt_rem[k] = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			nxt_num[k] = {src_num[k][NUM_W-2:0], 1'b0};
			nxt_quo[k] = {src_quo[k][NUM_W-2:0], ge};
		end
	end

	// Valid bits move with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_W; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (en) begin
			vld_s[0] <= in_vld;
			for (int k = 1; k < NUM_W; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NUM_W; k++) begin
				num_s[k]  <= nxt_num[k];
				quo_s[k]  <= nxt_quo[k];
				rem_s[k]  <= nxt_rem[k];
				den_s[k]  <= src_den[k];
				side_s[k] <= src_side[k];
			end
		end
	end

	assign out_vld  = vld_s[NUM_W-1];
	assign quo      = quo_s[NUM_W-1];
	assign rem      = rem_s[NUM_W-1];
	assign side_out = side_s[NUM_W-1];

endmodule
